[hdl/bfe_pkg.sv]
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types and constants of the bitmap field and find-first engine.
// ----------------------------------------------------------------------------
package bfe_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int NUM_WORDS_DEF = 16;

  localparam int IDX_W  = 10;
  localparam int FLD_W  = 7;
  localparam int DATA_W = 64;
  localparam int CMD_W  = 2;

  // reciprocal scaling used for division by the word size
  localparam int DIV_SH  = 20;
  localparam int RECIP_W = 18;
  localparam int PROD_W  = IDX_W + RECIP_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ       = 2'd0,
    CMD_WRITE      = 2'd1,
    CMD_FIND_SET   = 2'd2,
    CMD_FIND_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_OFFS,
    S_CHECK,
    S_RD,
    S_RESP
  } state_t;

endpackage

[hdl/bfe_ram.sv]
// ----------------------------------------------------------------------------
// bfe_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/bfe_field.sv]
// ----------------------------------------------------------------------------
// bfe_field
// Field extract and masked field insert on one bitmap word.
// ----------------------------------------------------------------------------
module bfe_field #(
  parameter int WORD_BITS = bfe_pkg::WORD_BITS_DEF,
  localparam int OW = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0]      word,
  input  logic [OW-1:0]             off,
  input  logic [bfe_pkg::FLD_W-1:0] width,
  input  logic [bfe_pkg::DATA_W-1:0] value,
  output logic [bfe_pkg::DATA_W-1:0] rfield,
  output logic [WORD_BITS-1:0]      wword
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] shifted;

  always_comb begin
    mask    = ~({WORD_BITS{1'b1}} << width);
    shifted = (word >> off) & mask;
    rfield  = bfe_pkg::DATA_W'(shifted);
    wword   = (word & ~(mask << off)) | ((value[WORD_BITS-1:0] & mask) << off);
  end

endmodule

[hdl/bfe_scan.sv]
// ----------------------------------------------------------------------------
// bfe_scan
// Per-word search unit: optional inversion, low-bit masking, first-one index.
// ----------------------------------------------------------------------------
module bfe_scan #(
  parameter int WORD_BITS = bfe_pkg::WORD_BITS_DEF,
  localparam int OW = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic                 invert,
  input  logic                 first,
  input  logic [OW-1:0]        off,
  output logic                 hit,
  output logic [OW-1:0]        tz
);

  logic [WORD_BITS-1:0] x;
  logic [WORD_BITS-1:0] lowest;

  always_comb begin
    x = invert ? ~word : word;
    if (first) begin
      x = x & ({WORD_BITS{1'b1}} << off);
    end
    hit    = |x;
    // isolate the lowest set bit, then encode it
    lowest = x & (~x + {{(WORD_BITS-1){1'b0}}, 1'b1});
    tz     = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lowest[j]) begin
        tz = tz | OW'(j);
      end
    end
  end

endmodule

[hdl/bitmap_field_and_find_first_engine_top.sv]
// ----------------------------------------------------------------------------
// bitmap_field_and_find_first_engine_top
// Bitmap of NUM_WORDS words with field read/write and find-first searches.
//
//   channel | handshake           | payload
//   in      | in_valid/in_ready   | cmd bit_index field_width write_value end_index
//   out     | out_valid/out_ready | read_data found found_index range_error
//
// Field reads and writes go from transfer through S_DIV, S_OFFS, S_CHECK and
// S_RD to a valid result in S_RESP; rejected requests skip S_RD. Searches stay
// in S_RD for each of the n words scanned (1 to NUM_WORDS): the RAM read port
// delivers one word per cycle to the scan. After reset a clearing pass zeroes
// the RAM; in_ready stays low meanwhile. One request is in flight at a time;
// in_ready is low until its result has been transferred.
// ----------------------------------------------------------------------------
module bitmap_field_and_find_first_engine_top #(
  parameter int WORD_BITS = bfe_pkg::WORD_BITS_DEF,
  parameter int NUM_WORDS = bfe_pkg::NUM_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfe_pkg::CMD_W-1:0]    in_cmd,
  input  logic [bfe_pkg::IDX_W-1:0]    in_bit_index,
  input  logic [bfe_pkg::FLD_W-1:0]    in_field_width,
  input  logic [bfe_pkg::DATA_W-1:0]   in_write_value,
  input  logic [bfe_pkg::IDX_W-1:0]    in_end_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bfe_pkg::DATA_W-1:0]   out_read_data,
  output logic                         out_found,
  output logic [bfe_pkg::IDX_W-1:0]    out_found_index,
  output logic                         out_range_error
);

  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int OW = $clog2(WORD_BITS);
  localparam int IW = bfe_pkg::IDX_W;
  localparam int BW = IW + 1;
  localparam logic [bfe_pkg::RECIP_W-1:0] RECIP =
    bfe_pkg::RECIP_W'((2 ** bfe_pkg::DIV_SH + WORD_BITS - 1) / WORD_BITS);
  localparam logic [BW-1:0] NW_C   = BW'(NUM_WORDS);
  localparam logic [BW-1:0] WB_C   = BW'(WORD_BITS);
  localparam logic [AW-1:0] LAST_C = AW'(NUM_WORDS - 1);

  bfe_pkg::state_t state_r, state_nxt;

  bfe_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [IW-1:0]                 start_r, start_nxt;
  logic [IW-1:0]                 end_r, end_nxt;
  logic [bfe_pkg::FLD_W-1:0]     width_r, width_nxt;
  logic [bfe_pkg::DATA_W-1:0]    value_r, value_nxt;
  logic [IW-1:0]                 ws_r, ws_nxt;
  logic [IW-1:0]                 we_r, we_nxt;
  logic [OW-1:0]                 off_r, off_nxt;
  logic [BW-1:0]                 base_r, base_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  logic                          first_r, first_nxt;
  logic [AW-1:0]                 clr_r, clr_nxt;
  logic [bfe_pkg::DATA_W-1:0]    rdata_r, rdata_nxt;
  logic                          found_r, found_nxt;
  logic [IW-1:0]                 fidx_r, fidx_nxt;
  logic                          err_r, err_nxt;

  logic [bfe_pkg::PROD_W-1:0]    prod_s, prod_e;
  logic [IW-1:0]                 wbase;
  logic                          is_field;
  logic                          err_c;
  logic                          scan_done;
  logic [BW-1:0]                 hit_idx;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [WORD_BITS-1:0]          ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [WORD_BITS-1:0]          ram_rdata;

  logic [bfe_pkg::DATA_W-1:0]    fld_rdata;
  logic [WORD_BITS-1:0]          fld_wword;
  logic                          scan_hit;
  logic [OW-1:0]                 scan_tz;

  bfe_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfe_field #(
    .WORD_BITS (WORD_BITS)
  ) u_field (
    .word   (ram_rdata),
    .off    (off_r),
    .width  (width_r),
    .value  (value_r),
    .rfield (fld_rdata),
    .wword  (fld_wword)
  );

  bfe_scan #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word   (ram_rdata),
    .invert (cmd_r == bfe_pkg::CMD_FIND_CLEAR),
    .first  (first_r),
    .off    (off_r),
    .hit    (scan_hit),
    .tz     (scan_tz)
  );

  // datapath helpers
  always_comb begin
    prod_s    = bfe_pkg::PROD_W'(start_r) * bfe_pkg::PROD_W'(RECIP);
    prod_e    = bfe_pkg::PROD_W'(end_r) * bfe_pkg::PROD_W'(RECIP);
    wbase     = IW'(ws_r * IW'(WORD_BITS));
    is_field  = (cmd_r == bfe_pkg::CMD_READ) || (cmd_r == bfe_pkg::CMD_WRITE);
    if (is_field) begin
      err_c = (width_r == '0) || (BW'(width_r) > WB_C) ||
              ((BW'(off_r) + BW'(width_r)) > WB_C) || (BW'(ws_r) >= NW_C);
    end else begin
      err_c = (end_r < start_r) || (BW'(we_r) >= NW_C);
    end
    scan_done = (idx_r == we_r[AW-1:0]);
    hit_idx   = base_r + BW'(scan_tz);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfe_pkg::S_CLEAR: begin
        if (clr_r == LAST_C) begin
          state_nxt = bfe_pkg::S_IDLE;
        end
      end
      bfe_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = bfe_pkg::S_DIV;
        end
      end
      bfe_pkg::S_DIV:   state_nxt = bfe_pkg::S_OFFS;
      bfe_pkg::S_OFFS:  state_nxt = bfe_pkg::S_CHECK;
      bfe_pkg::S_CHECK: state_nxt = err_c ? bfe_pkg::S_RESP : bfe_pkg::S_RD;
      bfe_pkg::S_RD: begin
        if (is_field || scan_hit || scan_done) begin
          state_nxt = bfe_pkg::S_RESP;
        end
      end
      bfe_pkg::S_RESP: begin
        if (out_ready) begin
          state_nxt = bfe_pkg::S_IDLE;
        end
      end
      default: state_nxt = bfe_pkg::S_CLEAR;
    endcase
  end

  // register next values and ram control
  always_comb begin
    cmd_nxt   = cmd_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    width_nxt = width_r;
    value_nxt = value_r;
    ws_nxt    = ws_r;
    we_nxt    = we_r;
    off_nxt   = off_r;
    base_nxt  = base_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    clr_nxt   = clr_r;
    rdata_nxt = rdata_r;
    found_nxt = found_r;
    fidx_nxt  = fidx_r;
    err_nxt   = err_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = fld_wword;
    ram_raddr = idx_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      bfe_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      bfe_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd_nxt   = bfe_pkg::cmd_t'(in_cmd);
        start_nxt = in_bit_index;
        end_nxt   = in_end_index;
        width_nxt = in_field_width;
        value_nxt = in_write_value;
      end
      bfe_pkg::S_DIV: begin
        ws_nxt = IW'(prod_s >> bfe_pkg::DIV_SH);
        we_nxt = IW'(prod_e >> bfe_pkg::DIV_SH);
      end
      bfe_pkg::S_OFFS: begin
        off_nxt  = OW'(start_r - wbase);
        base_nxt = BW'(wbase);
      end
      bfe_pkg::S_CHECK: begin
        ram_raddr = ws_r[AW-1:0];
        idx_nxt   = ws_r[AW-1:0];
        first_nxt = 1'b1;
        rdata_nxt = '0;
        found_nxt = 1'b0;
        fidx_nxt  = '0;
        err_nxt   = err_c;
      end
      bfe_pkg::S_RD: begin
        case (cmd_r)
          bfe_pkg::CMD_READ: begin
            rdata_nxt = fld_rdata;
          end
          bfe_pkg::CMD_WRITE: begin
            ram_we = 1'b1;
          end
          default: begin
            if (scan_hit) begin
              if (hit_idx <= BW'(end_r)) begin
                found_nxt = 1'b1;
                fidx_nxt  = hit_idx[IW-1:0];
              end
            end else if (!scan_done) begin
              // fetch the next word while this one is scanned
              ram_raddr = idx_r + AW'(1);
              idx_nxt   = idx_r + AW'(1);
              base_nxt  = base_r + WB_C;
              first_nxt = 1'b0;
            end
          end
        endcase
      end
      bfe_pkg::S_RESP: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfe_pkg::S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    width_r <= width_nxt;
    value_r <= value_nxt;
    ws_r    <= ws_nxt;
    we_r    <= we_nxt;
    off_r   <= off_nxt;
    base_r  <= base_nxt;
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    rdata_r <= rdata_nxt;
    found_r <= found_nxt;
    fidx_r  <= fidx_nxt;
    err_r   <= err_nxt;
  end

  assign out_read_data   = rdata_r;
  assign out_found       = found_r;
  assign out_found_index = fidx_r;
  assign out_range_error = err_r;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output both open");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_read_data == '0 && !out_found &&
      out_found_index == '0)
    else $error("rejected request carries data");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_found_index >= start_r &&
      out_found_index <= end_r && out_read_data == '0)
    else $error("found index outside search range");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");
`endif

endmodule
